[sv/hddc_pkg.sv]
// ----------------------------------------------------------------------------
// hddc_pkg
// Shared types, constants and the control program of the drive controller.
// ----------------------------------------------------------------------------
package hddc_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_SPEED_MAX   = 3'd0;
  localparam logic [2:0] REG_SPEED_MIN   = 3'd1;
  localparam logic [2:0] REG_TURN_MAX    = 3'd2;
  localparam logic [2:0] REG_ARRIVE_DIST = 3'd3;
  localparam logic [2:0] REG_ALIGN_ANGLE = 3'd4;
  localparam logic [2:0] REG_TURN_GAIN   = 3'd5;
  localparam logic [2:0] REG_DIST_GAIN_P = 3'd6;
  localparam logic [2:0] REG_DIST_GAIN_D = 3'd7;

  // register reset values
  localparam logic [15:0] RST_SPEED_MAX   = 16'd750;
  localparam logic [15:0] RST_SPEED_MIN   = 16'd200;
  localparam logic [14:0] RST_TURN_MAX    = 15'd500;
  localparam logic [23:0] RST_ARRIVE_DIST = 24'd150;
  localparam logic [14:0] RST_ALIGN_ANGLE = 15'd200;
  localparam logic [15:0] RST_TURN_GAIN   = 16'd768;
  localparam logic [15:0] RST_DIST_GAIN_P = 16'd512;
  localparam logic [15:0] RST_DIST_GAIN_D = 16'd6144;

  // angle constants in centidegrees
  localparam logic signed [17:0] FULL_CIRCLE = 18'sd36000;
  localparam logic signed [17:0] HALF_CIRCLE = 18'sd18000;

  // mrad per centidegree, Q20 (pi/18)
  localparam logic [17:0] MRAD_PER_CDEG = 18'd183011;

  // shared multiplier operand widths
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // micro-operations of the datapath
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_WRAP,
    OP_DIFF,
    OP_FOLD,
    OP_MAG,
    OP_MUL_RAD,
    OP_MUL_GAIN,
    OP_RATE,
    OP_DELTA,
    OP_MUL_P,
    OP_MUL_D,
    OP_SUM,
    OP_CLAMP,
    OP_OUT
  } op_t;

  // sequencing conditions
  typedef enum logic [1:0] {
    COND_NEXT,      // fall through to next step
    COND_WAIT_IN,   // hold until input beat; jump when goal reached
    COND_WAIT_OUT   // hold until output slot free, then jump
  } cond_t;

  localparam int PC_W = 4;

  // step addresses
  localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [PC_W-1:0] STEP_OUT  = 4'd13;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // control program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_OUT, cond: COND_WAIT_OUT, target: STEP_IDLE};
    case (pc)
      4'd0:  w = '{op: OP_LOAD,     cond: COND_WAIT_IN,  target: STEP_OUT};
      4'd1:  w = '{op: OP_WRAP,     cond: COND_NEXT,     target: STEP_IDLE};
      4'd2:  w = '{op: OP_DIFF,     cond: COND_NEXT,     target: STEP_IDLE};
      4'd3:  w = '{op: OP_FOLD,     cond: COND_NEXT,     target: STEP_IDLE};
      4'd4:  w = '{op: OP_MAG,      cond: COND_NEXT,     target: STEP_IDLE};
      4'd5:  w = '{op: OP_MUL_RAD,  cond: COND_NEXT,     target: STEP_IDLE};
      4'd6:  w = '{op: OP_MUL_GAIN, cond: COND_NEXT,     target: STEP_IDLE};
      4'd7:  w = '{op: OP_RATE,     cond: COND_NEXT,     target: STEP_IDLE};
      4'd8:  w = '{op: OP_DELTA,    cond: COND_NEXT,     target: STEP_IDLE};
      4'd9:  w = '{op: OP_MUL_P,    cond: COND_NEXT,     target: STEP_IDLE};
      4'd10: w = '{op: OP_MUL_D,    cond: COND_NEXT,     target: STEP_IDLE};
      4'd11: w = '{op: OP_SUM,      cond: COND_NEXT,     target: STEP_IDLE};
      4'd12: w = '{op: OP_CLAMP,    cond: COND_NEXT,     target: STEP_IDLE};
      4'd13: w = '{op: OP_OUT,      cond: COND_WAIT_OUT, target: STEP_IDLE};
      default: w = '{op: OP_OUT,    cond: COND_WAIT_OUT, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[sv/heading_distance_drive_controller.sv]
// A beat is loaded at the idle step. When the goal is reached the program
// jumps straight to the output step; otherwise it runs the 14-step
// control program that runs all products through one 35x18 multiplier.
// A new beat is taken only when the program is back at the idle step.
// The finished result sits in an output register; the next item is taken
// while it waits. Reset restores register defaults and clears the history.
// ----------------------------------------------------------------------------
// heading_distance_drive_controller
// Waypoint heading and distance controller: a microcoded sequencer drives a
// small datapath with one shared multiplier to form speed and turn commands.
// ----------------------------------------------------------------------------
module heading_distance_drive_controller (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [16:0] heading,
  input  logic signed [16:0] goal_bearing,
  input  logic [23:0]        goal_distance,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        linear_speed,
  output logic signed [15:0] turn_rate,
  output logic               aligned,
  output logic               goal_reached
);

  // configuration registers
  logic [15:0] speed_max;
  logic [15:0] speed_min;
  logic [14:0] turn_max;
  logic [23:0] arrive_dist;
  logic [14:0] align_angle;
  logic [15:0] turn_gain;
  logic [15:0] gain_p;
  logic [15:0] gain_d;

  // sequencer
  logic [hddc_pkg::PC_W-1:0] pc;
  logic [hddc_pkg::PC_W-1:0] pc_next;
  hddc_pkg::ucode_t          uw;
  logic                      fire;

  // datapath registers
  logic signed [16:0] head_raw;
  logic signed [16:0] bear_raw;
  logic [23:0]        cur_dist;
  logic [23:0]        previous_distance;
  logic               reached;
  logic signed [17:0] head_w;
  logic signed [17:0] bear_w;
  logic signed [17:0] diff;
  logic               neg;
  logic [16:0]        mag;
  logic [hddc_pkg::MUL_P_W-1:0] prod;
  logic [14:0]        rate_mag;
  logic [23:0]        delta;
  logic [39:0]        acc;
  logic [31:0]        speed_raw;
  logic [15:0]        speed;

  // combinational helpers
  logic [hddc_pkg::MUL_A_W-1:0] mul_a;
  logic [hddc_pkg::MUL_B_W-1:0] mul_b;
  logic [hddc_pkg::MUL_P_W-1:0] mul_p;
  logic signed [17:0] head_x;
  logic signed [17:0] bear_x;
  logic [50:0]        rate_rnd;
  logic [20:0]        rate_q;
  logic [41:0]        speed_sum;
  logic [15:0]        speed_hi;
  logic               out_free;
  logic               align_now;

  assign uw       = hddc_pkg::ucode_rom(pc);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (pc == hddc_pkg::STEP_IDLE);

  // step counter with conditional jumps
  always_comb begin
    pc_next = pc;
    fire    = 1'b0;
    case (uw.cond)
      hddc_pkg::COND_NEXT: begin
        fire    = 1'b1;
        pc_next = pc + 1'b1;
      end
      hddc_pkg::COND_WAIT_IN: begin
        if (in_valid) begin
          fire    = 1'b1;
          pc_next = (goal_distance <= arrive_dist) ? uw.target : pc + 1'b1;
        end
      end
      hddc_pkg::COND_WAIT_OUT: begin
        if (out_free) begin
          fire    = 1'b1;
          pc_next = uw.target;
        end
      end
      default: begin
        pc_next = hddc_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= hddc_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.op)
      hddc_pkg::OP_MUL_RAD: begin
        mul_a = hddc_pkg::MUL_A_W'(mag);
        mul_b = hddc_pkg::MRAD_PER_CDEG;
      end
      hddc_pkg::OP_MUL_GAIN: begin
        mul_a = prod[hddc_pkg::MUL_A_W-1:0];
        mul_b = hddc_pkg::MUL_B_W'(turn_gain);
      end
      hddc_pkg::OP_MUL_P: begin
        mul_a = hddc_pkg::MUL_A_W'(cur_dist);
        mul_b = hddc_pkg::MUL_B_W'(gain_p);
      end
      hddc_pkg::OP_MUL_D: begin
        mul_a = hddc_pkg::MUL_A_W'(delta);
        mul_b = hddc_pkg::MUL_B_W'(gain_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = hddc_pkg::MUL_P_W'(mul_a) * hddc_pkg::MUL_P_W'(mul_b);

  // angle wrap, rounding and clamp terms
  assign head_x    = 18'(head_raw);
  assign bear_x    = 18'(bear_raw);
  assign rate_rnd  = prod[50:0] + 51'd536870912;
  assign rate_q    = rate_rnd[50:30];
  assign speed_sum = 42'(acc) + 42'(prod[39:0]) + 42'd512;
  assign speed_hi  = (speed_raw > 32'(speed_max)) ? speed_max : speed_raw[15:0];
  assign align_now = (mag <= 17'(align_angle));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_max   <= hddc_pkg::RST_SPEED_MAX;
      speed_min   <= hddc_pkg::RST_SPEED_MIN;
      turn_max    <= hddc_pkg::RST_TURN_MAX;
      arrive_dist <= hddc_pkg::RST_ARRIVE_DIST;
      align_angle <= hddc_pkg::RST_ALIGN_ANGLE;
      turn_gain   <= hddc_pkg::RST_TURN_GAIN;
      gain_p      <= hddc_pkg::RST_DIST_GAIN_P;
      gain_d      <= hddc_pkg::RST_DIST_GAIN_D;
    end else if (cfg_write) begin
      case (cfg_index)
        hddc_pkg::REG_SPEED_MAX:   speed_max   <= cfg_data[15:0];
        hddc_pkg::REG_SPEED_MIN:   speed_min   <= cfg_data[15:0];
        hddc_pkg::REG_TURN_MAX:    turn_max    <= cfg_data[14:0];
        hddc_pkg::REG_ARRIVE_DIST: arrive_dist <= cfg_data;
        hddc_pkg::REG_ALIGN_ANGLE: align_angle <= cfg_data[14:0];
        hddc_pkg::REG_TURN_GAIN:   turn_gain   <= cfg_data[15:0];
        hddc_pkg::REG_DIST_GAIN_P: gain_p      <= cfg_data[15:0];
        hddc_pkg::REG_DIST_GAIN_D: gain_d      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // datapath, one micro-operation per step
  always_ff @(posedge clk) begin
    if (fire) begin
      case (uw.op)
        hddc_pkg::OP_LOAD: begin
          head_raw <= heading;
          bear_raw <= goal_bearing;
          cur_dist <= goal_distance;
          reached  <= (goal_distance <= arrive_dist);
        end
        hddc_pkg::OP_WRAP: begin
          head_w <= (head_x < 0) ? head_x + hddc_pkg::FULL_CIRCLE : head_x;
          bear_w <= (bear_x < 0) ? bear_x + hddc_pkg::FULL_CIRCLE : bear_x;
        end
        hddc_pkg::OP_DIFF: begin
          diff <= bear_w - head_w;
        end
        hddc_pkg::OP_FOLD: begin
          if (diff < 0) begin
            if (diff < -hddc_pkg::HALF_CIRCLE) begin
              diff <= diff + hddc_pkg::FULL_CIRCLE;
              neg  <= 1'b0;
            end else begin
              neg  <= 1'b1;
            end
          end else if (diff > hddc_pkg::HALF_CIRCLE) begin
            diff <= hddc_pkg::FULL_CIRCLE - diff;
            neg  <= 1'b1;
          end else begin
            neg  <= 1'b0;
          end
        end
        hddc_pkg::OP_MAG: begin
          mag <= (diff < 0) ? 17'(-diff) : 17'(diff);
        end
        hddc_pkg::OP_MUL_RAD, hddc_pkg::OP_MUL_GAIN, hddc_pkg::OP_MUL_P: begin
          prod <= mul_p;
        end
        hddc_pkg::OP_RATE: begin
          rate_mag <= (rate_q > 21'(turn_max)) ? turn_max : rate_q[14:0];
        end
        hddc_pkg::OP_DELTA: begin
          delta <= (previous_distance > cur_dist) ? previous_distance - cur_dist
                                                  : cur_dist - previous_distance;
        end
        hddc_pkg::OP_MUL_D: begin
          acc  <= prod[39:0];
          prod <= mul_p;
        end
        hddc_pkg::OP_SUM: begin
          speed_raw <= speed_sum[41:10];
        end
        hddc_pkg::OP_CLAMP: begin
          speed <= (speed_hi < speed_min) ? speed_min : speed_hi;
        end
        default: ;
      endcase
    end
  end

  // distance history, updated as each result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_distance <= '0;
    end else if (fire && uw.op == hddc_pkg::OP_OUT) begin
      previous_distance <= cur_dist;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && uw.op == hddc_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && uw.op == hddc_pkg::OP_OUT) begin
      goal_reached <= reached;
      if (reached) begin
        linear_speed <= '0;
        turn_rate    <= '0;
        aligned      <= 1'b0;
      end else begin
        linear_speed <= speed;
        aligned      <= align_now;
        if (align_now) begin
          turn_rate <= '0;
        end else if (neg) begin
          turn_rate <= -$signed(16'(rate_mag));
        end else begin
          turn_rate <= $signed(16'(rate_mag));
        end
      end
    end
  end

  // checks
  a_reached_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && goal_reached |-> linear_speed == 16'd0 && turn_rate == 16'sd0 && !aligned)
    else $error("goal reached but command not stopped");

  a_aligned_straight: assert property (@(posedge clk) disable iff (rst)
    out_valid && aligned |-> turn_rate == 16'sd0 && !goal_reached)
    else $error("aligned result carries a turn rate");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer took a second beat while busy");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= hddc_pkg::STEP_OUT)
    else $error("step counter ran past the program");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(linear_speed) && $stable(turn_rate))
    else $error("output result changed while stalled");

endmodule
